>>> rtl/core/sacl_pkg.sv
// ============================================================================
// sacl_pkg
// shared types and constants of the set-associative cache lru simulator
// ============================================================================
package sacl_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

	// access outcome codes
	localparam logic [1:0] OUTCOME_HIT   = 2'd0;
	localparam logic [1:0] OUTCOME_FILL  = 2'd1;
	localparam logic [1:0] OUTCOME_EVICT = 2'd2;

	localparam int STAMP_W = 32;
	localparam int COUNT_W = 32;

	// input beat
	typedef struct packed {
		logic        kind;
		logic [63:0] address;
	} sacl_in_t;

	// output beat
	typedef struct packed {
		logic [1:0]         outcome;
		logic               last;
		logic [COUNT_W-1:0] hit_total;
		logic [COUNT_W-1:0] miss_total;
		logic [COUNT_W-1:0] evict_total;
	} sacl_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the accepted address
		logic clr_step; // write one zero row of the clearing sweep
		logic read;     // issue the set read
		logic eval;     // register the set search
		logic commit;   // write back the row, update totals, load output
		logic last;     // final access of the item
	} sacl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
	} sacl_sts_t;

endpackage

>>> rtl/core/sacl_ram.sv
// ============================================================================
// sacl_ram
// generic simple dual-port ram, one write and one registered read port
// ============================================================================
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/sacl_ctrl.sv
// ============================================================================
// sacl_ctrl
// sequencing of the clearing sweep, the accesses of an item and the output beat
// ============================================================================
module sacl_ctrl
	import sacl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_kind,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output sacl_cmd_t cmd,
	input  sacl_sts_t sts
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   second_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   commit;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign commit   = (state_q == ST_WRITE) && out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.read     = (state_q == ST_READ);
		cmd.eval     = (state_q == ST_EVAL);
		cmd.commit   = commit;
		cmd.last     = !second_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_d = second_q ? ST_READ : ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				second_q <= in_kind;
			end else if (commit) begin
				second_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/sacl_dp.sv
// ============================================================================
// sacl_dp
// config registers, address split, set row search and write-back, totals
// ============================================================================
module sacl_dp
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [63:0]            in_address,
	input  sacl_cmd_t              cmd,
	output sacl_sts_t              sts,
	output sacl_out_t              out_item
);

	localparam int SETS      = 1 << MAX_SET_BITS;
	localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int NW2       = 1 << WAY_W;
	localparam int PAIRS     = NW2 / 2;
	localparam int TAG_W     = ADDR_WIDTH;
	localparam int WAY_BITS  = 1 + TAG_W + STAMP_W;
	localparam int ROW_W     = MAX_WAYS * WAY_BITS;
	// field offsets inside one way slot: stamp low, tag, valid on top
	localparam int TAG_LO    = STAMP_W;
	localparam int VLD_POS   = STAMP_W + TAG_W;

	localparam logic [3:0] SB_MAX = 4'(MAX_SET_BITS);

	// configuration
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	// access state
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [TAG_W-1:0]      tag_q;
	logic [SET_IDX_W-1:0]  set_q;
	logic [SET_IDX_W-1:0]  clr_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic [COUNT_W-1:0]    hits_q;
	logic [COUNT_W-1:0]    misses_q;
	logic [COUNT_W-1:0]    evicts_q;
	sacl_out_t             out_q;

	// search results
	logic                  hit_q;
	logic [WAY_W-1:0]      hit_way_q;
	logic                  empty_q;
	logic [WAY_W-1:0]      empty_way_q;
	logic [STAMP_W-1:0]    pstamp_q [PAIRS];
	logic [WAY_W-1:0]      pidx_q   [PAIRS];

	logic [3:0]            sb;
	logic [6:0]            total;
	logic [TAG_W-1:0]      tag_c;
	logic [ADDR_WIDTH-1:0] blk_shift;
	logic [SET_IDX_W-1:0]  set_c;
	logic [WCNT_W-1:0]     wc;

	logic                  ram_we;
	logic [SET_IDX_W-1:0]  ram_waddr;
	logic [ROW_W-1:0]      ram_wdata;
	logic [ROW_W-1:0]      row;

	logic                  hit_c;
	logic [WAY_W-1:0]      hit_way_c;
	logic                  empty_c;
	logic [WAY_W-1:0]      empty_way_c;
	logic [STAMP_W-1:0]    pstamp_c [PAIRS];
	logic [WAY_W-1:0]      pidx_c   [PAIRS];

	logic [STAMP_W-1:0]    tstamp [PAIRS];
	logic [WAY_W-1:0]      tidx   [PAIRS];
	logic [WAY_W-1:0]      way_sel;
	logic [1:0]            outcome_c;
	logic [STAMP_W-1:0]    stamp_next;
	logic [ROW_W-1:0]      new_row;

	// address split
	always_comb begin
		sb        = (set_bits_q > SB_MAX) ? SB_MAX : set_bits_q;
		total     = {3'b000, sb} + {1'b0, block_bits_q};
		tag_c     = (total >= 7'd64) ? '0 : TAG_W'(addr_q >> total);
		blk_shift = addr_q >> block_bits_q;
		set_c     = blk_shift[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << sb);
	end

	// ways in use, zero acts as one, clamped to the built ways
	always_comb begin
		if (ways_q == 4'd0) begin
			wc = WCNT_W'(1);
		end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
			wc = WCNT_W'(MAX_WAYS);
		end else begin
			wc = WCNT_W'(ways_q);
		end
	end

	// one row holds every way of a set
	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read),
		.raddr (set_c),
		.rdata (row)
	);

	assign ram_we    = cmd.clr_step || cmd.commit;
	assign ram_waddr = cmd.clr_step ? clr_q : set_q;
	assign ram_wdata = cmd.clr_step ? '0 : new_row;
	assign sts.clr_done = (clr_q == SET_IDX_W'(SETS - 1));

	// hit and empty search, first level of the oldest-stamp tree
	always_comb begin
		logic [STAMP_W-1:0] s [NW2];
		logic               use_w;
		hit_c       = 1'b0;
		hit_way_c   = '0;
		empty_c     = 1'b0;
		empty_way_c = '0;
		for (int w = 0; w < NW2; w++) begin
			s[w] = '1;
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			use_w = (w < int'(wc));
			if (use_w) begin
				s[w] = row[w*WAY_BITS +: STAMP_W];
				if (row[w*WAY_BITS + VLD_POS] &&
				    (row[w*WAY_BITS + TAG_LO +: TAG_W] == tag_q)) begin
					hit_c     = 1'b1;
					hit_way_c = WAY_W'(w);
				end
				if (!row[w*WAY_BITS + VLD_POS]) begin
					empty_c     = 1'b1;
					empty_way_c = WAY_W'(w);
				end
			end
		end
		// ties go to the lower way
		for (int p = 0; p < PAIRS; p++) begin
			if (s[2*p+1] < s[2*p]) begin
				pstamp_c[p] = s[2*p+1];
				pidx_c[p]   = WAY_W'(2*p + 1);
			end else begin
				pstamp_c[p] = s[2*p];
				pidx_c[p]   = WAY_W'(2*p);
			end
		end
	end

	// remaining tree levels, way choice and new row
	always_comb begin
		for (int p = 0; p < PAIRS; p++) begin
			tstamp[p] = pstamp_q[p];
			tidx[p]   = pidx_q[p];
		end
		for (int l = 0; l < WAY_W - 1; l++) begin
			for (int i = 0; i < PAIRS; i++) begin
				if (i < (PAIRS >> (l + 1))) begin
					if (tstamp[2*i+1] < tstamp[2*i]) begin
						tstamp[i] = tstamp[2*i+1];
						tidx[i]   = tidx[2*i+1];
					end else begin
						tstamp[i] = tstamp[2*i];
						tidx[i]   = tidx[2*i];
					end
				end
			end
		end
		if (hit_q) begin
			way_sel   = hit_way_q;
			outcome_c = OUTCOME_HIT;
		end else if (empty_q) begin
			way_sel   = empty_way_q;
			outcome_c = OUTCOME_FILL;
		end else begin
			way_sel   = tidx[0];
			outcome_c = OUTCOME_EVICT;
		end
		stamp_next = stamp_q + STAMP_W'(1);
		new_row    = row;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == way_sel) begin
				new_row[w*WAY_BITS + VLD_POS]         = 1'b1;
				new_row[w*WAY_BITS + TAG_LO +: TAG_W] = tag_q;
				new_row[w*WAY_BITS +: STAMP_W]        = stamp_next;
			end
		end
	end

	// config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= 4'd1;
			clr_q        <= '0;
			stamp_q      <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			evicts_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SET_BITS:   set_bits_q   <= cfg_wdata[3:0];
					CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
					CFG_WAYS:       ways_q       <= cfg_wdata[3:0];
					default:        ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + SET_IDX_W'(1);
			end
			if (cmd.commit) begin
				stamp_q <= stamp_next;
				case (outcome_c)
					OUTCOME_HIT:  hits_q <= hits_q + COUNT_W'(1);
					OUTCOME_FILL: misses_q <= misses_q + COUNT_W'(1);
					default: begin
						misses_q <= misses_q + COUNT_W'(1);
						evicts_q <= evicts_q + COUNT_W'(1);
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= in_address[ADDR_WIDTH-1:0];
		end
		if (cmd.read) begin
			tag_q <= tag_c;
			set_q <= set_c;
		end
		if (cmd.eval) begin
			hit_q       <= hit_c;
			hit_way_q   <= hit_way_c;
			empty_q     <= empty_c;
			empty_way_q <= empty_way_c;
			for (int p = 0; p < PAIRS; p++) begin
				pstamp_q[p] <= pstamp_c[p];
				pidx_q[p]   <= pidx_c[p];
			end
		end
		if (cmd.commit) begin
			out_q.outcome     <= outcome_c;
			out_q.last        <= cmd.last;
			out_q.hit_total   <= (outcome_c == OUTCOME_HIT) ? hits_q + COUNT_W'(1) : hits_q;
			out_q.miss_total  <= (outcome_c == OUTCOME_HIT) ? misses_q
			                                                 : misses_q + COUNT_W'(1);
			out_q.evict_total <= (outcome_c == OUTCOME_EVICT) ? evicts_q + COUNT_W'(1)
			                                                   : evicts_q;
		end
	end

	assign out_item = out_q;

endmodule

>>> rtl/core/set_assoc_cache_lru_sim_top.sv
// ============================================================================
// set_assoc_cache_lru_sim_top
// tag-only set-associative cache simulator with lru replacement
// ============================================================================
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------
// in       | in_valid / in_stall    | in_item  (kind, address)
// out      | out_valid / out_stall  | out_item (outcome, last, totals)
// cfg      | cfg_we                 | cfg_index, cfg_wdata
//
// each access runs set row read, search, write-back in turn; the single
// row ram port pair sets this. a load/store item makes one access, a modify
// item two; in_stall stays high until its last write-back, held by out_stall.
// after reset a clearing sweep writes 2^MAX_SET_BITS zero rows, one a cycle,
// with in_stall high; configuration writes are taken during the sweep.
// one output register holds a finished beat while the next item is accepted.
//
module set_assoc_cache_lru_sim_top
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input beats
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sacl_in_t               in_item,
	// result beats
	output logic                   out_valid,
	input  logic                   out_stall,
	output sacl_out_t              out_item,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	sacl_cmd_t cmd;
	sacl_sts_t sts;

	// sequencing: clear sweep, access steps, output slot
	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_item.kind),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// config, row ram, lru search and running totals
	sacl_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_address (in_item.address),
		.cmd        (cmd),
		.sts        (sts),
		.out_item   (out_item)
	);

endmodule
